FILE: src/jbp_pkg.sv
// Package for the JPEG bit packer with byte stuffing.
// Holds the shared constants, the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package jbp_pkg;

   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 6;
   localparam int BYTE_W         = 8;
   localparam int HELD_W         = 3;
   localparam int WORD_W         = VALUE_W + BYTE_W;
   localparam int LEFT_W         = 6;
   localparam int MAX_FIELD_BITS = 32;
   localparam int COUNT_LIMIT    = (MAX_FIELD_BITS < VALUE_W) ? MAX_FIELD_BITS : VALUE_W;

   localparam logic [BYTE_W-1:0] STUFF_TRIGGER = 8'hFF;
   localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_STUFF
   } state_type;

   typedef struct packed {
      logic load;
      logic emit_data;
      logic emit_stuff;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic has_byte;
      logic stuff_next;
      logic slot_free;
   } status_type;

endpackage

FILE: src/jbp_ctrl.sv
// Controller of the JPEG bit packer: sequences load, byte emission, stuffing and commit.
// Depends on jbp_pkg.
`timescale 1ns / 1ps

module jbp_ctrl
   import jbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.has_byte) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.slot_free) begin
               cmd.emit_data = 1'b1;
               state_in      = status.stuff_next ? ST_STUFF : ST_EMIT;
            end
         end
         ST_STUFF: begin
            if (status.slot_free) begin
               cmd.emit_stuff = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/jbp_datapath.sv
// Datapath of the JPEG bit packer: bit accumulator, pending partial byte and output register.
// Depends on jbp_pkg.
`timescale 1ns / 1ps

module jbp_datapath
   import jbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_mode,
   input  logic [VALUE_W-1:0] req_bits_value,
   input  logic [COUNT_W-1:0] req_bits_count,
   input  logic               req_is_marker,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_last_of_run
);

   // Pending bits are kept left aligned; unused low bits are always zero.
   logic [BYTE_W-1:0] pend_ff;
   logic [HELD_W-1:0] held_ff;

   // Working word, left aligned, with left_ff valid bits from the top.
   logic [WORD_W-1:0] word_ff, word_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic              stuff_en_ff, stuff_en_in;

   logic              valid_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;

   logic [COUNT_W-1:0] cnt_sat;
   logic [WORD_W-1:0]  placed;
   logic [LEFT_W-1:0]  left_rest;
   logic [BYTE_W-1:0]  top_byte;

   assign cnt_sat   = (req_bits_count > COUNT_W'(COUNT_LIMIT)) ? COUNT_W'(COUNT_LIMIT)
                                                               : req_bits_count;
   // Shifting by (WORD_W - count) drops every value bit above the field length.
   assign placed    = {{BYTE_W{1'b0}}, req_bits_value} << (LEFT_W'(WORD_W) - cnt_sat);
   assign top_byte  = word_ff[WORD_W-1 -: BYTE_W];
   assign left_rest = left_ff - LEFT_W'(BYTE_W);

   assign status.has_byte   = (left_ff >= LEFT_W'(BYTE_W));
   assign status.stuff_next = stuff_en_ff && (top_byte == STUFF_TRIGGER);
   assign status.slot_free  = !valid_ff || rsp_ready;

   always_comb begin
      word_in     = word_ff;
      left_in     = left_ff;
      stuff_en_in = stuff_en_ff;
      if (cmd.load) begin
         if (req_mode == MODE_FLUSH) begin
            word_in     = {pend_ff, {VALUE_W{1'b0}}};
            left_in     = (held_ff != '0) ? LEFT_W'(BYTE_W) : '0;
            stuff_en_in = 1'b1;
         end else begin
            word_in     = {pend_ff, {VALUE_W{1'b0}}} | (placed >> held_ff);
            left_in     = LEFT_W'(held_ff) + LEFT_W'(cnt_sat);
            stuff_en_in = !req_is_marker;
         end
      end else if (cmd.emit_data) begin
         word_in = word_ff << BYTE_W;
         left_in = left_rest;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      left_ff     <= left_in;
      stuff_en_ff <= stuff_en_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         held_ff <= '0;
      end else if (cmd.commit) begin
         pend_ff <= top_byte;
         held_ff <= left_ff[HELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_data || cmd.emit_stuff) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_data) begin
         byte_ff <= top_byte;
         last_ff <= (left_rest < LEFT_W'(BYTE_W)) && !status.stuff_next;
      end else if (cmd.emit_stuff) begin
         byte_ff <= STUFF_BYTE;
         last_ff <= (left_ff < LEFT_W'(BYTE_W));
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

FILE: src/jpeg_bit_packer_byte_stuffing.sv
// Top level of the JPEG entropy bit packer with 0xFF byte stuffing.
// Instantiates jbp_ctrl and jbp_datapath; depends on jbp_pkg.
//
//   Channel | Ports                                        | Direction
//   --------+----------------------------------------------+----------
//   request | req_valid/ready, mode, bits_value/count,     | in
//           | is_marker                                    |
//   response| rsp_valid/ready, out_byte, last_of_run       | out
//
// An item takes a load step, one emit step per output byte (data or stuffing
// zero), and a closing step that stores the leftover bits. The single output
// byte register sets the pace of one byte per cycle while the response side
// is ready. Reset is synchronous and active high; it empties the partial byte
// and drops any pending beat. A stalled response beat holds the controller
// in place; a new request beat is taken once the previous item is closed,
// even while its final beat still waits on the response side.
`timescale 1ns / 1ps

module jpeg_bit_packer_byte_stuffing
   import jbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [VALUE_W-1:0] req_bits_value,
   input  logic [COUNT_W-1:0] req_bits_count,
   input  logic               req_is_marker,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_last_of_run
);

   // Commands go from the controller to the datapath, status comes back.
   cmd_type    cmd;
   status_type status;

   // The controller walks each item through load, emit, optional stuffing
   // and commit, and only accepts a request beat while idle.
   jbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath merges new bits below the pending ones in a left-aligned
   // 40-bit word and shifts out one byte per emit command.
   jbp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_bits_value  (req_bits_value),
      .req_bits_count  (req_bits_count),
      .req_is_marker   (req_is_marker),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: tb/tb_jpeg_bit_packer_byte_stuffing.sv
// Self-checking testbench for the JPEG bit packer with 0xFF byte stuffing.
// Depends on jbp_pkg and jpeg_bit_packer_byte_stuffing, with its jbp_ctrl and jbp_datapath.
// Drives write and flush beats and checks every output byte against a packer model.
`timescale 1ns / 1ps

module tb_jpeg_bit_packer_byte_stuffing
   import jbp_pkg::*;
();

   // The watchdog trips after this many cycles without any accepted beat. The
   // longest quiet stretch in a correct run is the long receiver hold-off below.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_CYCLES    = 24;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } stream_byte_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic               req_mode        = MODE_WRITE;
   logic [VALUE_W-1:0] req_bits_value  = '0;
   logic [COUNT_W-1:0] req_bits_count  = '0;
   logic               req_is_marker   = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic               rsp_last_of_run;

   // Bytes the packer model says must come out, oldest first.
   stream_byte_type expected_bytes_q[$];
   // Bytes caused by the beat currently being modeled.
   stream_byte_type item_bytes_q[$];

   // Packer model state: pending bits sit in the low (8 - model_free) bits.
   logic [BYTE_W-1:0] model_partial = '0;
   logic [3:0]        model_free    = 4'd8;

   int  fail_count    = 0;
   int  quiet_cycles  = 0;
   bit  src_idle_on   = 1'b1;
   bit  sink_idle_on  = 1'b1;
   int  hold_left     = 0;
   int  stall_left    = 0;

   always #4 clock = ~clock;

   jpeg_bit_packer_byte_stuffing uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_bits_value  (req_bits_value),
      .req_bits_count  (req_bits_count),
      .req_is_marker   (req_is_marker),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // ---------------------------------------------------------------------
   // Packer model
   // ---------------------------------------------------------------------

   // Queues one output byte for the current beat. A data byte of 0xFF is
   // followed by a stuffing zero unless stuffing is suppressed for markers.
   function automatic void append_byte(input logic [BYTE_W-1:0] data, input logic stuff);
      stream_byte_type entry;
      entry.data = data;
      entry.last = 1'b0;
      item_bytes_q.push_back(entry);
      if (stuff && data == STUFF_TRIGGER) begin
         entry.data = STUFF_BYTE;
         item_bytes_q.push_back(entry);
      end
   endfunction

   // Applies one accepted beat to the model and queues the bytes it causes.
   // The final byte of each beat carries the last-of-run flag.
   function automatic void pack_bits(input logic m, input logic [VALUE_W-1:0] v,
                                     input logic [COUNT_W-1:0] c, input logic mk);
      logic [63:0]       acc;
      logic [BYTE_W-1:0] data;
      int                n;
      int                held;
      int                total;
      item_bytes_q.delete();
      held = 8 - int'(model_free);
      if (m == MODE_FLUSH) begin
         // A flush pads with zeros on the right and always applies stuffing.
         if (held != 0) begin
            data = model_partial << model_free;
            append_byte(data, 1'b1);
            model_partial = '0;
            model_free    = 4'd8;
         end
      end else begin
         // Oversized lengths saturate; a zero length leaves the state alone.
         n = (int'(c) > COUNT_LIMIT) ? COUNT_LIMIT : int'(c);
         if (n != 0) begin
            acc = ((64'(model_partial) & ((64'd1 << held) - 64'd1)) << n)
                  | (64'(v) & ((64'd1 << n) - 64'd1));
            total = held + n;
            while (total >= 8) begin
               total = total - 8;
               data  = 8'(acc >> total);
               append_byte(data, !mk);
            end
            model_partial = 8'(acc & ((64'd1 << total) - 64'd1));
            model_free    = 4'(8 - total);
         end
      end
      for (int i = 0; i < item_bytes_q.size(); i++) begin
         stream_byte_type entry;
         entry      = item_bytes_q[i];
         entry.last = (i == item_bytes_q.size() - 1);
         expected_bytes_q.push_back(entry);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one beat and waits for it to be accepted. Valid is left high on
   // return, so a back-to-back beat keeps it high without a glitch; an idle
   // gap, when one is drawn, lowers it first.
   task automatic send_item(input logic m, input logic [VALUE_W-1:0] v,
                            input logic [COUNT_W-1:0] c, input logic mk);
      if (src_idle_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_bits_value <= v;
      req_bits_count <= c;
      req_is_marker  <= mk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pack_bits(m, v, c, mk);
   endtask

   // Draws one beat shaped like an entropy-coded stream: mostly short codes,
   // with some all-ones runs to provoke stuffing, markers, flushes, empty
   // writes and oversized lengths mixed in.
   task automatic send_random_item();
      int                 pick;
      logic [VALUE_W-1:0] v;
      logic [COUNT_W-1:0] c;
      pick = $urandom_range(0, 99);
      v    = $urandom;
      if (pick < 6) begin
         send_item(MODE_FLUSH, v, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end else if (pick < 10) begin
         // Byte-aligned header marker: flush first, then 0xFFxx without stuffing.
         send_item(MODE_FLUSH, v, '0, 1'b0);
         send_item(MODE_WRITE, {16'($urandom), 8'hFF, 8'($urandom)}, 6'd16, 1'b1);
      end else if (pick < 14) begin
         send_item(MODE_WRITE, v, 6'd0, 1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
         send_item(MODE_WRITE, v, 6'($urandom_range(33, 63)), 1'b0);
      end else if (pick < 32) begin
         c = 6'($urandom_range(1, 32));
         send_item(MODE_WRITE, ~(VALUE_W'($urandom_range(0, 3))), c,
                   1'($urandom_range(0, 9) == 0));
      end else begin
         c = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(17, 32))
                                          : 6'($urandom_range(1, 16));
         send_item(MODE_WRITE, v, c, 1'($urandom_range(0, 19) == 0));
      end
   endtask

   task automatic wait_for_drain();
      while (expected_bytes_q.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Ready changes at the falling edge. A long hold-off, when one is armed,
   // takes precedence over the random stall bursts.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each accepted output beat is compared with the oldest expected byte.
   always @(posedge clock) begin
      stream_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes_q.size() == 0) begin
            $error("unexpected beat: out_byte %h last_of_run %b",
                   rsp_out_byte, rsp_last_of_run);
            fail_count++;
         end else begin
            want = expected_bytes_q.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte mismatch: expected %h, actual %h", want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run mismatch: expected %b, actual %b",
                      want.last, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   // Ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes and every special case of the packer, in a fixed order
   // whose outputs are easy to follow by hand.
   task automatic test_directed();
      send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd0, 1'b0);  // empty write: nothing out
      send_item(MODE_FLUSH, 32'h0, 6'd0, 1'b0);          // empty flush: nothing out
      send_item(MODE_WRITE, 32'h0000_0001, 6'd1, 1'b0);
      send_item(MODE_WRITE, 32'h0000_007F, 6'd7, 1'b0);  // completes 0xFF, then stuffing
      send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b0); // full width, eight beats out
      send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b1); // full width, marker: no stuffing
      send_item(MODE_WRITE, 32'h0000_0005, 6'd3, 1'b0);
      send_item(MODE_FLUSH, 32'hFFFF_FFFF, 6'd63, 1'b1); // pads 101 to 0xA0
      send_item(MODE_WRITE, 32'h0000_001F, 6'd5, 1'b0);
      send_item(MODE_FLUSH, 32'h0, 6'd0, 1'b1);          // marker flag ignored on a flush
      send_item(MODE_WRITE, 32'h1234_5678, 6'd63, 1'b0); // oversized length saturates
      send_item(MODE_WRITE, 32'hDEAD_BEEF, 6'd33, 1'b0);
      send_item(MODE_WRITE, 32'hA5A5_5A5A, 6'd40, 1'b1);
      send_item(MODE_WRITE, 32'hFFFF_FFF5, 6'd4, 1'b0);  // upper value bits ignored
      send_item(MODE_FLUSH, 32'h0, 6'd0, 1'b0);
      send_item(MODE_WRITE, 32'h0000_FFD8, 6'd16, 1'b1); // start-of-image marker
      send_item(MODE_WRITE, 32'h0000_00FF, 6'd8, 1'b0);  // aligned 0xFF, stuffed
      send_item(MODE_WRITE, 32'h0000_000F, 6'd4, 1'b0);
      send_item(MODE_WRITE, 32'h0000_00FF, 6'd8, 1'b0);  // 0xFF straddling a boundary
      send_item(MODE_WRITE, 32'h8000_0000, 6'd32, 1'b0);
      send_item(MODE_WRITE, 32'h0000_0000, 6'd31, 1'b0);
      send_item(MODE_FLUSH, 32'h0, 6'd0, 1'b0);
   endtask

   task automatic test_random_stream(input int n);
      repeat (n) send_random_item();
   endtask

   // The receiver holds off for a long stretch while full-width writes keep
   // coming, so the output register and the packer back up into the request side.
   task automatic test_output_backpressure();
      src_idle_on = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      hold_left = LONG_HOLD;
      repeat (20) send_item(MODE_WRITE, $urandom, 6'd32, 1'b0);
      repeat (10) send_random_item();
      src_idle_on = 1'b1;
   endtask

   // The sender pauses until every byte has come out, then resumes mid-stream.
   task automatic test_drain_pause();
      repeat (10) send_random_item();
      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (10) send_random_item();
   endtask

   // Back-to-back beats with both sides always ready.
   task automatic test_full_rate(input int n);
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      repeat (n) send_random_item();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_stream(240);
      test_output_backpressure();
      test_drain_pause();
      test_full_rate(50);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      // Give the block time to show any stray beat after the last expected one.
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_bytes_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
